/* rtl/itwm_pkg.sv */
// ----------------------------------------------------------------------------
// itwm_pkg: shared types and constants of the interval timer window mean
// Field widths, window geometry, per-channel state record and result word.
// ----------------------------------------------------------------------------
package itwm_pkg;

  // field widths of the ports
  localparam int CH_PORT_W = 3;
  localparam int TIME_W    = 32;

  // window geometry, a power of two so the mean is a plain shift
  localparam int WINDOW = 16;
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int SUM_W  = TIME_W + SLOT_W;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  // result queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_AW + 1;

  // mark kinds
  localparam logic MARK_START = 1'b0;
  localparam logic MARK_END   = 1'b1;

  // per-channel record held in the channel memory
  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [SUM_W-1:0]  sum;
    logic [SLOT_W-1:0] slot;
    logic              wrapped;
  } chan_state_t;

  // one result word
  typedef struct packed {
    logic [CH_PORT_W-1:0] channel;
    logic [TIME_W-1:0]    duration;
    logic [TIME_W-1:0]    mean;
  } out_word_t;

endpackage

/* rtl/itwm_ram.sv */
// ----------------------------------------------------------------------------
// itwm_ram: simple dual-port synchronous memory
// One write port, one read port with registered read data (read-old on a
// same-address collision).
// ----------------------------------------------------------------------------
module itwm_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/itwm_out_fifo.sv */
// ----------------------------------------------------------------------------
// itwm_out_fifo: result queue
// Small register queue that decouples the compute pipeline from the output
// handshake; its fill level feeds the input credit check.
// ----------------------------------------------------------------------------
module itwm_out_fifo (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  itwm_pkg::out_word_t                 push_word,
  output logic                                pop_valid,
  input  logic                                pop_ready,
  output itwm_pkg::out_word_t                 pop_word,
  output logic [itwm_pkg::FIFO_CNT_W-1:0]     level
);

  itwm_pkg::out_word_t                  mem_r [itwm_pkg::FIFO_DEPTH];
  logic [itwm_pkg::FIFO_AW-1:0]         wp_r;
  logic [itwm_pkg::FIFO_AW-1:0]         rp_r;
  logic [itwm_pkg::FIFO_CNT_W-1:0]      cnt_r;
  logic                                 pop;

  assign pop       = pop_valid & pop_ready;
  assign pop_valid = (cnt_r != '0);
  assign pop_word  = mem_r[rp_r];
  assign level     = cnt_r;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_word;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + itwm_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + itwm_pkg::FIFO_AW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + itwm_pkg::FIFO_CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - itwm_pkg::FIFO_CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* rtl/interval_timer_window_mean.sv */
// ----------------------------------------------------------------------------
// interval_timer_window_mean: per-channel interval timers with window mean
// Start marks store a timestamp, end marks give the duration and the mean of
// the channel's last sixteen durations.
// ----------------------------------------------------------------------------
// Usage
//   cfg_wr_en/cfg_wr_data write the enable bit; while it is 0 every mark is
//   taken and dropped. Write it only while the block is idle.
//   in_*: one mark per word (req_type 0 = start, 1 = end), valid/ready.
//   out_*: one word per end mark that is not dropped: channel, duration, window mean.
//   Each mark passes the stage 1 and stage 2 registers; an end mark's result
//   is then written into the output queue, which offers it on out_valid.
//   Throughput: one mark per cycle while in_ready is high. Channel state
//   and the duration ring live in two registered-read memories; back-to-back
//   marks to one channel resolve by forwarding from the two pipeline writes in flight.
//   in_ready comes only from registers: it is high while the output queue
//   has room for every word already in the pipeline plus one more. When the
//   receiver stalls, up to four results collect in the queue and then
//   in_ready drops; nothing is lost.
//   Reset: enable clears to 0, the pipeline and queue empty, and all channel
//   state reads as zero at once (per-channel valid bits and a wrap flag per
//   channel stand in for a clearing pass).
// ----------------------------------------------------------------------------
module interval_timer_window_mean #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_wr_en,
  input  logic                            cfg_wr_data,
  // mark input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_req_type,
  input  logic [itwm_pkg::CH_PORT_W-1:0]  in_channel,
  input  logic [itwm_pkg::TIME_W-1:0]     in_timestamp,
  // result output
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [itwm_pkg::CH_PORT_W-1:0]  out_channel_out,
  output logic [itwm_pkg::TIME_W-1:0]     out_duration,
  output logic [itwm_pkg::TIME_W-1:0]     out_window_mean
);

  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CH_X   = (CH_W > itwm_pkg::CH_PORT_W) ? CH_W : itwm_pkg::CH_PORT_W;
  localparam int HA_W   = CH_W + itwm_pkg::SLOT_W;
  localparam int CHAN_W = $bits(itwm_pkg::chan_state_t);

  // configuration
  logic enable_r;

  // input decode
  logic                               in_acc;
  logic                               enter;
  logic                               ch_ok;
  logic [CH_X-1:0]                    ch_ext;
  logic [CH_W-1:0]                    in_addr;

  // stage 1
  logic                               s1_vld_r;
  logic                               s1_end_r;
  logic [itwm_pkg::CH_PORT_W-1:0]     s1_ch_r;
  logic [CH_W-1:0]                    s1_addr_r;
  logic [itwm_pkg::TIME_W-1:0]        s1_ts_r;
  logic                               cv_rd_r;
  logic [CHAN_W-1:0]                  chan_rdata;
  itwm_pkg::chan_state_t              st1;
  itwm_pkg::chan_state_t              s2_st_nxt;
  logic [itwm_pkg::TIME_W-1:0]        dur1;
  logic [HA_W-1:0]                    hist_raddr;

  // stage 2
  logic                               s2_vld_r;
  logic                               s2_end_r;
  logic [itwm_pkg::CH_PORT_W-1:0]     s2_ch_r;
  logic [CH_W-1:0]                    s2_addr_r;
  logic [itwm_pkg::TIME_W-1:0]        s2_dur_r;
  logic [HA_W-1:0]                    s2_haddr_r;
  logic                               s2_old_ok_r;
  itwm_pkg::chan_state_t              s2_st_r;
  logic [itwm_pkg::TIME_W-1:0]        hist_rdata;
  logic [itwm_pkg::TIME_W-1:0]        old_dur;
  logic [itwm_pkg::SUM_W-1:0]         sum_new;
  itwm_pkg::chan_state_t              s2_new;

  // write issued at the previous edge
  logic                               wr_vld_r;
  logic [CH_W-1:0]                    wr_addr_r;
  itwm_pkg::chan_state_t              wr_data_r;

  // channel record valid bits
  logic [NUM_CHANNELS-1:0]            chv_r;

  // output queue
  itwm_pkg::out_word_t                res_word;
  itwm_pkg::out_word_t                pop_word;
  logic [itwm_pkg::FIFO_CNT_W-1:0]    q_level;
  logic                               res_push;

  // enable register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else if (cfg_wr_en) begin
      enable_r <= cfg_wr_data;
    end
  end

  // credit check: queue room for everything in flight plus the new word
  assign in_ready = (q_level + itwm_pkg::FIFO_CNT_W'(s1_vld_r)
                     + itwm_pkg::FIFO_CNT_W'(s2_vld_r))
                    < itwm_pkg::FIFO_CNT_W'(itwm_pkg::FIFO_DEPTH);

  // accept and filter
  assign in_acc  = in_valid & in_ready;
  assign ch_ok   = (32'(in_channel) < 32'(NUM_CHANNELS));
  assign enter   = in_acc & enable_r & ch_ok;
  assign ch_ext  = CH_X'(in_channel);
  assign in_addr = ch_ext[CH_W-1:0];

  // channel record memory, read at accept, written from stage 2
  itwm_ram #(
    .DATA_W (CHAN_W),
    .DEPTH  (NUM_CHANNELS),
    .ADDR_W (CH_W)
  ) u_chan_ram (
    .clk   (clk),
    .we    (s2_vld_r),
    .waddr (s2_addr_r),
    .wdata (CHAN_W'(s2_new)),
    .raddr (in_addr),
    .rdata (chan_rdata)
  );

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= enter;
    end
  end

  always_ff @(posedge clk) begin
    s1_end_r  <= in_req_type;
    s1_ch_r   <= in_channel;
    s1_addr_r <= in_addr;
    s1_ts_r   <= in_timestamp;
    cv_rd_r   <= chv_r[in_addr];
  end

  // stage 1 record with forwarding: stage 2 wins over the last write
  always_comb begin
    st1 = cv_rd_r ? itwm_pkg::chan_state_t'(chan_rdata) : '0;
    if (wr_vld_r && (wr_addr_r == s1_addr_r)) begin
      st1 = wr_data_r;
    end
    if (s2_vld_r && (s2_addr_r == s1_addr_r)) begin
      st1 = s2_new;
    end
  end

  // stage 1 update: stamp on start, ring slot advance on end
  always_comb begin
    s2_st_nxt = st1;
    if (s1_end_r == itwm_pkg::MARK_START) begin
      s2_st_nxt.stamp = s1_ts_r;
    end else begin
      s2_st_nxt.slot    = st1.slot + itwm_pkg::SLOT_W'(1);
      s2_st_nxt.wrapped = st1.wrapped | (st1.slot == itwm_pkg::SLOT_LAST);
    end
  end

  assign dur1       = s1_ts_r - st1.stamp;
  assign hist_raddr = {s1_addr_r, st1.slot};

  // duration ring memory, read in stage 1, written in stage 2
  itwm_ram #(
    .DATA_W (itwm_pkg::TIME_W),
    .DEPTH  (NUM_CHANNELS * itwm_pkg::WINDOW),
    .ADDR_W (HA_W)
  ) u_hist_ram (
    .clk   (clk),
    .we    (s2_vld_r & s2_end_r),
    .waddr (s2_haddr_r),
    .wdata (s2_dur_r),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_end_r    <= s1_end_r;
    s2_ch_r     <= s1_ch_r;
    s2_addr_r   <= s1_addr_r;
    s2_dur_r    <= dur1;
    s2_haddr_r  <= hist_raddr;
    s2_old_ok_r <= st1.wrapped;
    s2_st_r     <= s2_st_nxt;
  end

  // stage 2 running sum; a slot not yet written since reset counts as zero
  assign old_dur = s2_old_ok_r ? hist_rdata : '0;
  assign sum_new = s2_st_r.sum - itwm_pkg::SUM_W'(old_dur)
                   + itwm_pkg::SUM_W'(s2_dur_r);

  always_comb begin
    s2_new = s2_st_r;
    if (s2_end_r == itwm_pkg::MARK_END) begin
      s2_new.sum = sum_new;
    end
  end

  // last write, kept for the item that read the memory at that edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_vld_r <= 1'b0;
      chv_r    <= '0;
    end else begin
      wr_vld_r <= s2_vld_r;
      if (s2_vld_r) begin
        chv_r[s2_addr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= s2_addr_r;
    wr_data_r <= s2_new;
  end

  // result word
  assign res_push         = s2_vld_r & (s2_end_r == itwm_pkg::MARK_END);
  assign res_word.channel  = s2_ch_r;
  assign res_word.duration = s2_dur_r;
  assign res_word.mean     = sum_new[itwm_pkg::SLOT_W +: itwm_pkg::TIME_W];

  itwm_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_word (res_word),
    .pop_valid (out_valid),
    .pop_ready (out_ready),
    .pop_word  (pop_word),
    .level     (q_level)
  );

  assign out_channel_out = pop_word.channel;
  assign out_duration    = pop_word.duration;
  assign out_window_mean = pop_word.mean;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: scoreboard bench for the interval timer window mean
// A driver streams start and end marks with random gaps, a monitor takes
// result words with random stalls, and an in-bench predictor keeps its own
// copy of the start stamps, the duration rings and the running sums to check
// every result word field by field.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NUM_CH       = 8;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int MAX_SHOWN    = 10;

  // one input word
  typedef struct packed {
    logic                           req_type;
    logic [itwm_pkg::CH_PORT_W-1:0] channel;
    logic [itwm_pkg::TIME_W-1:0]    timestamp;
  } mark_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_wr_en = 1'b0;
  logic                           cfg_wr_data = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           in_req_type = 1'b0;
  logic [itwm_pkg::CH_PORT_W-1:0] in_channel = '0;
  logic [itwm_pkg::TIME_W-1:0]    in_timestamp = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [itwm_pkg::CH_PORT_W-1:0] out_channel_out;
  logic [itwm_pkg::TIME_W-1:0]    out_duration;
  logic [itwm_pkg::TIME_W-1:0]    out_window_mean;

  // stimulus and expected results
  mark_t               mark_queue[$];
  itwm_pkg::out_word_t pending_intervals[$];
  int                  marks_unaccepted = 0;
  int                  mismatch_count = 0;
  int                  cycle_count = 0;

  // predictor state
  logic                        enable_copy = 1'b0;
  logic [itwm_pkg::TIME_W-1:0] mark_stamp[NUM_CH];
  logic [itwm_pkg::TIME_W-1:0] dur_ring[NUM_CH][itwm_pkg::WINDOW];
  logic [itwm_pkg::SUM_W-1:0]  ring_total[NUM_CH];
  int                          ring_next[NUM_CH];

  // stimulus shaping
  logic [itwm_pkg::TIME_W-1:0] gen_start[NUM_CH];

  // driver and monitor pacing
  int                  in_gap = 0;
  int                  in_burst = 0;
  int                  out_stall = 0;
  int                  out_burst = 0;
  itwm_pkg::out_word_t next_interval;
  itwm_pkg::out_word_t seen_interval;
  mark_t               next_mark;

  interval_timer_window_mean #(
    .NUM_CHANNELS(NUM_CH)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_channel     (in_channel),
    .in_timestamp   (in_timestamp),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_channel_out(out_channel_out),
    .out_duration   (out_duration),
    .out_window_mean(out_window_mean)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int c = 0; c < NUM_CH; c++) begin
      mark_stamp[c] = '0;
      ring_total[c] = '0;
      ring_next[c]  = 0;
      gen_start[c]  = '0;
      for (int s = 0; s < itwm_pkg::WINDOW; s++) dur_ring[c][s] = '0;
    end
  end

  // expected result of one accepted mark, 1 when a result word follows
  function automatic bit predict_interval(input mark_t m,
                                          output itwm_pkg::out_word_t r);
    logic [itwm_pkg::TIME_W-1:0] dur;
    int                          s;
    r = '0;
    if (!enable_copy) return 1'b0;
    if (m.req_type == itwm_pkg::MARK_START) begin
      mark_stamp[m.channel] = m.timestamp;
      return 1'b0;
    end
    dur = m.timestamp - mark_stamp[m.channel];
    s = ring_next[m.channel];
    ring_total[m.channel] = ring_total[m.channel]
                            - itwm_pkg::SUM_W'(dur_ring[m.channel][s])
                            + itwm_pkg::SUM_W'(dur);
    dur_ring[m.channel][s] = dur;
    ring_next[m.channel] = (s + 1) % itwm_pkg::WINDOW;
    r.channel  = m.channel;
    r.duration = dur;
    r.mean     = itwm_pkg::TIME_W'(ring_total[m.channel]
                                   / itwm_pkg::SUM_W'(itwm_pkg::WINDOW));
    return 1'b1;
  endfunction

  // cycles to idle before the next word, with runs of back-to-back words
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  task automatic note_mismatch(input string what, input itwm_pkg::out_word_t want,
                               input itwm_pkg::out_word_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN)
      $display("%0t %s: expected ch %0d dur %h mean %h, got ch %0d dur %h mean %h",
               $time, what, want.channel, want.duration, want.mean,
               got.channel, got.duration, got.mean);
  endtask

  task automatic push_mark(input logic kind, input int ch,
                           input logic [itwm_pkg::TIME_W-1:0] ts);
    mark_t m;
    m.req_type  = kind;
    m.channel   = itwm_pkg::CH_PORT_W'(ch);
    m.timestamp = ts;
    if (kind == itwm_pkg::MARK_START) gen_start[ch] = ts;
    mark_queue.push_back(m);
    marks_unaccepted++;
  endtask

  // random marks: mostly end marks timed from the last start, some focus runs
  task automatic queue_random_marks(input int n);
    int                          focus_ch;
    int                          focus_left;
    int                          ch;
    logic                        kind;
    logic [itwm_pkg::TIME_W-1:0] dur;
    logic [itwm_pkg::TIME_W-1:0] ts;
    focus_ch   = 0;
    focus_left = 0;
    for (int k = 0; k < n; k++) begin
      if (focus_left == 0 && $urandom_range(0, 9) == 0) begin
        focus_ch   = $urandom_range(0, NUM_CH - 1);
        focus_left = $urandom_range(4, 24);
      end
      if (focus_left > 0) begin
        ch = focus_ch;
        focus_left--;
      end else begin
        ch = $urandom_range(0, NUM_CH - 1);
      end
      kind = ($urandom_range(0, 2) == 0) ? itwm_pkg::MARK_START : itwm_pkg::MARK_END;
      case ($urandom_range(0, 3))
        0: dur = $urandom_range(0, 255);
        1: dur = $urandom;
        2: dur = 32'hFFFF_FFFF - $urandom_range(0, 255);
        default: dur = $urandom_range(0, 100000);
      endcase
      if ($urandom_range(0, 9) == 0) ts = $urandom;
      else ts = gen_start[ch] + dur;
      push_mark(kind, ch, ts);
    end
  endtask

  // block idle: all marks taken, all results seen, pipeline flushed
  task automatic wait_drained();
    while (marks_unaccepted != 0 || in_valid || pending_intervals.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(input logic v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    enable_copy = v;
  endtask

  // driver: one word at a time from the mark queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        if (predict_interval({in_req_type, in_channel, in_timestamp}, next_interval))
          pending_intervals.push_back(next_interval);
        marks_unaccepted--;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (mark_queue.size() != 0) begin
          next_mark = mark_queue.pop_front();
          in_valid     <= 1'b1;
          in_req_type  <= next_mark.req_type;
          in_channel   <= next_mark.channel;
          in_timestamp <= next_mark.timestamp;
          in_gap       <= draw_wait(in_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each taken word with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else if (out_valid && out_ready) begin
      seen_interval.channel  = out_channel_out;
      seen_interval.duration = out_duration;
      seen_interval.mean     = out_window_mean;
      if (pending_intervals.size() == 0) begin
        note_mismatch("unexpected word", '0, seen_interval);
      end else begin
        next_interval = pending_intervals.pop_front();
        if (seen_interval.channel !== next_interval.channel ||
            seen_interval.duration !== next_interval.duration ||
            seen_interval.mean !== next_interval.mean)
          note_mismatch("wrong word", next_interval, seen_interval);
      end
      out_stall = draw_wait(out_burst);
      if (out_stall > 0) out_ready <= 1'b0;
    end else if (out_stall > 0) begin
      if (out_stall == 1) out_ready <= 1'b1;
      out_stall = out_stall - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // reset and phases
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // disabled out of reset: every mark dropped
    push_mark(itwm_pkg::MARK_END, 0, 32'h0000_1234);
    queue_random_marks(6);
    wait_drained();

    write_enable(1'b1);

    // end marks with nothing started, from the cleared stamp
    push_mark(itwm_pkg::MARK_END, 0, 32'h0000_0000);
    push_mark(itwm_pkg::MARK_END, 7, 32'hFFFF_FFFF);
    // duration wrapping past zero, then a repeated end on the same start
    push_mark(itwm_pkg::MARK_START, 3, 32'hFFFF_FFF0);
    push_mark(itwm_pkg::MARK_END, 3, 32'h0000_0010);
    push_mark(itwm_pkg::MARK_END, 3, 32'h0000_0030);
    push_mark(itwm_pkg::MARK_START, 1, 32'h0000_0000);
    push_mark(itwm_pkg::MARK_END, 1, 32'hFFFF_FFFF);
    // largest durations until the ring wraps, sum past the time width
    push_mark(itwm_pkg::MARK_START, 5, 32'h0000_0000);
    for (int k = 0; k < 17; k++) push_mark(itwm_pkg::MARK_END, 5, 32'hFFFF_FFFF);
    queue_random_marks(800);
    wait_drained();

    // disabled again mid run: state must stay as it was
    write_enable(1'b0);
    queue_random_marks(30);
    wait_drained();

    write_enable(1'b1);
    queue_random_marks(820);
    wait_drained();

    while (pending_intervals.size() != 0) begin
      next_interval = pending_intervals.pop_front();
      note_mismatch("missing word", next_interval, '0);
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
